[sv/alb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ambient light brightness tracker package
// Shared widths, register indexes, reset values and controller types.
// ----------------------------------------------------------------------------
package alb_pkg;

  localparam int LIGHT_W    = 12;
  localparam int BRIGHT_W   = 8;
  localparam int INT_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int OUT_W      = 16;

  localparam int PROD_W     = LIGHT_W + BRIGHT_W + 2;
  localparam int NUM_W      = LIGHT_W + BRIGHT_W;
  localparam int DIV_STEPS  = NUM_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYST      = 3'd4;

  localparam logic [LIGHT_W-1:0]  LIGHT_LO_RST  = 12'd0;
  localparam logic [LIGHT_W-1:0]  LIGHT_HI_RST  = 12'd4095;
  localparam logic [BRIGHT_W-1:0] BRIGHT_LO_RST = 8'd0;
  localparam logic [BRIGHT_W-1:0] BRIGHT_HI_RST = 8'd255;
  localparam logic [BRIGHT_W-1:0] HYST_RST      = 8'd0;
  localparam logic [10:0]         FILT_RST      = 11'd2047;
  localparam logic [BRIGHT_W-1:0] SMOOTH_RST    = 8'd127;
  localparam logic [INT_W-1:0]    SHOWN_RST     = 4'd0;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_STEP  = 8'b0000_0010,
    ST_LEVEL = 8'b0000_0100,
    ST_MULT  = 8'b0000_1000,
    ST_PREP  = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_MAP   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic level;
    logic mult;
    logic prep;
    logic div_step;
    logic map;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

[sv/alb_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ambient light brightness tracker datapath
// Configuration registers, light filter, linear map with a radix-4 divider,
// brightness smoothing and the output register.
// ----------------------------------------------------------------------------
module alb_datapath #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  alb_pkg::ctrl_cmd_t             cmd,
  output alb_pkg::dp_status_t            status,
  input  logic                           cfg_we,
  input  logic [alb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_action,
  input  logic [SAMPLE_BITS-1:0]         in_sample,
  output logic [alb_pkg::BRIGHT_W-1:0]   out_brightness,
  output logic [alb_pkg::INT_W-1:0]      out_intensity,
  output logic                           out_changed
);
  import alb_pkg::*;

  localparam int FW = (SAMPLE_BITS > LIGHT_W - 1) ? SAMPLE_BITS : LIGHT_W - 1;
  localparam int WW = ((SAMPLE_BITS > LIGHT_W) ? SAMPLE_BITS : LIGHT_W) + 1;
  localparam int LW = FW + 2;

  logic [LIGHT_W-1:0]  llo_r, lhi_r;
  logic [BRIGHT_W-1:0] blo_r, bhi_r, hyst_r;

  logic                   action_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [FW-1:0]          filt_r, filt_nxt;
  logic                   up_r, dn_r, gt_r, lt_r;
  logic [LIGHT_W-1:0]     x_r, x_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [LIGHT_W:0]   den_r;
  logic                   eq_r, neg_r;
  logic [NUM_W-1:0]       quo_r, quo_nxt;
  logic [LIGHT_W-1:0]     rem_r, rem_nxt, dabs_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [BRIGHT_W-1:0]    br_r, br_nxt;
  logic [BRIGHT_W-1:0]    smooth_r, smooth_nxt;
  logic [INT_W-1:0]       shown_r;
  logic [BRIGHT_W-1:0]    obr_r;
  logic [INT_W-1:0]       oint_r;
  logic                   ochg_r;

  // Filter step.
  logic [WW-1:0]      smask, f_w, s_w, mid_w, delta_w, inc_w, mov_w;
  logic [LIGHT_W:0]   mid_sum;
  logic               up_c, dn_c;

  assign smask   = {{(WW - SAMPLE_BITS){1'b0}}, {SAMPLE_BITS{1'b1}}};
  assign f_w     = WW'(filt_r);
  assign s_w     = WW'(sample_r);
  assign mid_sum = {1'b0, llo_r} + {1'b0, lhi_r};
  assign mid_w   = WW'(mid_sum[LIGHT_W:1]);
  assign up_c    = s_w > f_w;
  assign dn_c    = s_w < f_w;
  assign delta_w = up_c ? (s_w - f_w) : (f_w - s_w);
  assign inc_w   = (delta_w >> 3) | WW'(1);
  assign mov_w   = up_c ? (f_w + inc_w) : (dn_c ? (f_w - inc_w) : f_w);
  assign filt_nxt = FW'((action_r ? mid_w : mov_w) & smask);

  // Hysteresis and clamp to the light limits.
  logic signed [LW-1:0] lvl_s, hyst_s, lsum_s;
  logic [LW-2:0]        lpos, llo_e, lhi_e;

  assign lvl_s  = $signed(LW'(filt_r));
  assign hyst_s = $signed(LW'(hyst_r));
  assign lsum_s = up_r ? (lvl_s - hyst_s) : (dn_r ? (lvl_s + hyst_s) : lvl_s);
  assign lpos   = lsum_s[LW-1] ? '0 : lsum_s[LW-2:0];
  assign llo_e  = (LW-1)'(llo_r);
  assign lhi_e  = (LW-1)'(lhi_r);

  always_comb begin
    if (action_r) begin
      x_nxt = LIGHT_W'(filt_r);
    end else if (lpos < llo_e) begin
      x_nxt = llo_r;
    end else if (lpos > lhi_e) begin
      x_nxt = lhi_r;
    end else begin
      x_nxt = LIGHT_W'(lpos);
    end
  end

  // Map numerator and denominator.
  logic signed [LIGHT_W:0]  dx_s, den_s;
  logic signed [BRIGHT_W:0] db_s;
  logic [PROD_W-1:0]        prod_abs;
  logic [LIGHT_W:0]         den_abs;

  assign dx_s     = $signed({1'b0, x_r}) - $signed({1'b0, llo_r});
  assign db_s     = $signed({1'b0, bhi_r}) - $signed({1'b0, blo_r});
  assign den_s    = $signed({1'b0, lhi_r}) - $signed({1'b0, llo_r});
  assign prod_abs = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign den_abs  = den_r[LIGHT_W] ? (LIGHT_W+1)'(-den_r) : (LIGHT_W+1)'(den_r);

  // Two quotient bits per cycle.
  logic [LIGHT_W:0]   r1_t, r2_t, dext;
  logic [LIGHT_W-1:0] r1;
  logic               q1, q2;

  assign dext = {1'b0, dabs_r};
  assign r1_t = {rem_r, quo_r[NUM_W-1]};
  assign q1   = r1_t >= dext;
  assign r1   = q1 ? LIGHT_W'(r1_t - dext) : r1_t[LIGHT_W-1:0];
  assign r2_t = {r1, quo_r[NUM_W-2]};
  assign q2   = r2_t >= dext;
  assign rem_nxt = q2 ? LIGHT_W'(r2_t - dext) : r2_t[LIGHT_W-1:0];
  assign quo_nxt = {quo_r[NUM_W-3:0], q1, q2};
  assign status.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  logic [BRIGHT_W-1:0] q8;

  assign q8     = neg_r ? (BRIGHT_W'(0) - quo_r[BRIGHT_W-1:0]) : quo_r[BRIGHT_W-1:0];
  assign br_nxt = eq_r ? blo_r : (q8 + blo_r);

  // Brightness smoothing and display intensity.
  logic                up_cond, dn_cond, far, chg;
  logic [BRIGHT_W-1:0] sc;
  logic [INT_W-1:0]    di;

  assign up_cond = gt_r && (br_r > smooth_r);
  assign dn_cond = lt_r && (br_r < smooth_r);
  assign far     = ({1'b0, smooth_r} > ({1'b0, br_r} + (BRIGHT_W+1)'(1))) ||
                   ({1'b0, br_r} > ({1'b0, smooth_r} + (BRIGHT_W+1)'(1)));
  assign smooth_nxt = (action_r || up_cond || dn_cond || far) ? br_r : smooth_r;

  always_comb begin
    if (smooth_nxt < blo_r) begin
      sc = blo_r;
    end else if (smooth_nxt > bhi_r) begin
      sc = bhi_r;
    end else begin
      sc = smooth_nxt;
    end
  end

  assign di  = sc[INT_W-1:0];
  assign chg = !action_r && (di != shown_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      llo_r    <= LIGHT_LO_RST;
      lhi_r    <= LIGHT_HI_RST;
      blo_r    <= BRIGHT_LO_RST;
      bhi_r    <= BRIGHT_HI_RST;
      hyst_r   <= HYST_RST;
      filt_r   <= FW'(FILT_RST);
      smooth_r <= SMOOTH_RST;
      shown_r  <= SHOWN_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LIGHT_LO:  llo_r  <= cfg_data[LIGHT_W-1:0];
          REG_LIGHT_HI:  lhi_r  <= cfg_data[LIGHT_W-1:0];
          REG_BRIGHT_LO: blo_r  <= cfg_data[BRIGHT_W-1:0];
          REG_BRIGHT_HI: bhi_r  <= cfg_data[BRIGHT_W-1:0];
          REG_HYST:      hyst_r <= cfg_data[BRIGHT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.step) begin
        filt_r <= filt_nxt;
      end
      if (cmd.load) begin
        smooth_r <= smooth_nxt;
        if (chg) begin
          shown_r <= di;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_r <= in_action;
      sample_r <= in_sample;
    end
    if (cmd.step) begin
      up_r <= up_c;
      dn_r <= dn_c;
    end
    if (cmd.level) begin
      x_r  <= x_nxt;
      gt_r <= up_c;
      lt_r <= dn_c;
    end
    if (cmd.mult) begin
      prod_r <= dx_s * db_s;
      den_r  <= den_s;
      eq_r   <= (lhi_r == llo_r);
    end
    if (cmd.prep) begin
      neg_r  <= prod_r[PROD_W-1] ^ den_r[LIGHT_W];
      quo_r  <= prod_abs[NUM_W-1:0];
      dabs_r <= den_abs[LIGHT_W-1:0];
      rem_r  <= '0;
      cnt_r  <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
    if (cmd.map) begin
      br_r <= br_nxt;
    end
    if (cmd.load) begin
      obr_r  <= sc;
      oint_r <= chg ? di : shown_r;
      ochg_r <= chg;
    end
  end

  assign out_brightness = obr_r;
  assign out_intensity  = oint_r;
  assign out_changed    = ochg_r;

endmodule

[sv/alb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ambient light brightness tracker controller
// Sequences one transaction through the datapath and owns the output valid.
// ----------------------------------------------------------------------------
module alb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  alb_pkg::dp_status_t status,
  output alb_pkg::ctrl_cmd_t  cmd
);
  import alb_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = ST_LEVEL;
      end
      ST_LEVEL: begin
        cmd.level = 1'b1;
        state_nxt = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.map   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.load = slot_free;
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

[sv/ambient_light_brightness_tracker_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ambient light brightness tracker
// Filters light samples with hysteresis and maps them to a display brightness.
// ----------------------------------------------------------------------------
// Each input transaction either processes a light sample (tuser low) or
// recentres the filtered level (tuser high) and always yields exactly one
// result transaction. A transaction passes from acceptance through the step,
// level, multiply, prepare, divide and map states to the result register,
// which it loads once the output is not stalled, and the next one is accepted
// only after that; the linear map runs through a divider that retires two
// quotient bits per cycle. A finished result waits in the output register
// while the next transaction is accepted. Configuration writes are taken in
// every cycle and must only be issued while no transaction is in flight.
module ambient_light_brightness_tracker_core #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [SAMPLE_BITS-1:0] light_sample, zero padded to whole bytes.
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // [0] action.
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] brightness_level, [11:8] display_intensity, [12] intensity_changed.
  output logic [alb_pkg::OUT_W-1:0]           out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [alb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [alb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import alb_pkg::*;

  ctrl_cmd_t           cmd;
  dp_status_t          status;
  logic [BRIGHT_W-1:0] brightness;
  logic [INT_W-1:0]    intensity;
  logic                changed;

  assign cfg_ready = 1'b1;

  alb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  alb_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_action      (in_tuser),
    .in_sample      (in_tdata[SAMPLE_BITS-1:0]),
    .out_brightness (brightness),
    .out_intensity  (intensity),
    .out_changed    (changed)
  );

  assign out_tdata = {(OUT_W - BRIGHT_W - INT_W - 1)'(0), changed, intensity, brightness};

endmodule

[sv/alb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ambient light brightness tracker checker
// Port-level checks on the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module alb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [alb_pkg::OUT_W-1:0]   out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result transaction changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input accepted while a transaction was in progress.");

  a_change_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> out_tdata[11:8] == out_tdata[3:0])
    else $error("Changed intensity does not match the brightness low bits.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("Block not idle after reset.");

endmodule

bind ambient_light_brightness_tracker_core alb_checker u_alb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
